// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/q2e_pkg.sv =====
// Package: widths, CORDIC constants and angle table for quaternion to Euler conversion
package q2e_pkg;
  localparam int CordicStagesDefault = 16;
  localparam int TableSize = 24;
  localparam int CordicW = 46;
  localparam int AngleW = 28;
  localparam int ProdW = 32;
  localparam int SumW = 36;
  localparam logic signed [AngleW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngleW-1:0] z;
  } cvec_t;

  function automatic logic signed [AngleW-1:0] atan_tab(input int i);
    logic signed [AngleW-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = (i < TableSize) ? AngleW'(28'sd1 <<< (24 - i)) : '0;
    endcase
    return r;
  endfunction
endpackage

// ===== design/quaternion_to_euler_angles_top.sv =====
// Top level: quaternion to ZYX Euler angles, fully pipelined with output skid buffer
// channel | dir | tdata fields (low bit up)                    | tuser
// s_axis  | in  | quat_x[15:0] quat_y[31:16] quat_z quat_w       | -
// m_axis  | out | roll[15:0] pitch[30:16] yaw[46:31] 0-pad[47]  | pitch_clamped
// One transaction accepted per cycle while s_axis_tready is high.
// The depth comes from the front-end registers, the 29-stage square root and the CORDIC stage chain.
// Reset clears only the valid bits and the output buffer count and pointers; data registers carry no reset.
// A stall freezes the pipeline; a two-entry output buffer keeps s_axis_tready off m_axis_tready.
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STAGES = q2e_pkg::CordicStagesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [63:0] s_axis_tdata, // quat_x, quat_y, quat_z, quat_w
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [47:0] m_axis_tdata, // roll_angle, pitch_angle, yaw_angle
  output logic m_axis_tuser         // pitch_clamped
);
  localparam int NS = (CORDIC_STAGES > q2e_pkg::TableSize) ? q2e_pkg::TableSize : CORDIC_STAGES;
  localparam int FL = 32;
  localparam int LAT = FL + NS + 4;
  localparam int S = q2e_pkg::SumW;

  logic en;
  logic [LAT-1:0] vld;
  logic [1:0] cnt;

  // skid fifo of depth 2; pipeline advances when it has room or the last stage is empty
  logic [48:0] fifo [0:1];
  logic rd, wr;
  assign en = (cnt != 2'd2) || !vld[LAT-1];
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end

  logic signed [S-1:0] ry, rx, yy, yx, ps, pc;
  logic cl;
  q2e_front u_front (
    .clk, .en,
    .qx(s_axis_tdata[15:0]), .qy(s_axis_tdata[31:16]),
    .qz(s_axis_tdata[47:32]), .qw(s_axis_tdata[63:48]),
    .ry, .rx, .yy, .yx, .ps, .pc, .clamped(cl)
  );

  logic signed [15:0] roll, pitch, yaw;
  logic [NS+2:0] cld;
  always_ff @(posedge clk) if (en) cld <= {cld[NS+1:0], cl};

  q2e_cordic #(.STAGES(CORDIC_STAGES), .LIM(q2e_pkg::PiQ13), .LAT(1)) u_roll
    (.clk, .en, .yin(ry), .xin(rx), .angle(roll));
  q2e_cordic #(.STAGES(CORDIC_STAGES), .LIM(q2e_pkg::HalfPiQ13), .LAT(1)) u_pitch
    (.clk, .en, .yin(ps), .xin(pc), .angle(pitch));
  q2e_cordic #(.STAGES(CORDIC_STAGES), .LIM(q2e_pkg::PiQ13), .LAT(1)) u_yaw
    (.clk, .en, .yin(yy), .xin(yx), .angle(yaw));

  logic [48:0] res;
  assign res = {cld[NS+2], 1'b0, yaw, pitch[14:0], roll};
  assign rd = m_axis_tvalid && m_axis_tready;
  assign wr = en && vld[LAT-1];
  logic rp, wp;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rp <= 1'b0; wp <= 1'b0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk) if (wr) fifo[wp] <= res;
  assign m_axis_tvalid = cnt != 2'd0;
  assign m_axis_tdata = fifo[rp][47:0];
  assign m_axis_tuser = fifo[rp][48];
endmodule

// ===== design/q2e_cordic.sv =====
// Pipelined vectoring CORDIC: prerotation, normalization, one stage per iteration, rounding and saturation
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CordicStagesDefault,
  parameter int LIM = 25736,
  parameter int LAT = 4
) (
  input  logic clk,
  input  logic en,
  input  logic signed [q2e_pkg::SumW-1:0] yin,
  input  logic signed [q2e_pkg::SumW-1:0] xin,
  output logic signed [15:0] angle
);
  localparam int W = q2e_pkg::CordicW;
  localparam int N = (STAGES > q2e_pkg::TableSize) ? q2e_pkg::TableSize : STAGES;

  q2e_pkg::cvec_t pre;
  logic zero_in;
  logic signed [W-1:0] px, py;
  logic [W-1:0] mx, my, mm;
  logic [5:0] lz;
  q2e_pkg::cvec_t st [0:N];
  logic signed [q2e_pkg::AngleW-1:0] zr;
  logic signed [q2e_pkg::AngleW-12:0] rq;
  q2e_pkg::cvec_t norm_in;

  // quadrant fold
  always_comb begin
    px = W'(xin);
    py = W'(yin);
    zero_in = (xin == '0) && (yin == '0);
    pre = '{x: px, y: py, z: '0};
    if (xin < 0) begin
      if (yin >= 0) pre = '{x: py, y: -px, z: q2e_pkg::HalfPiQ24};
      else pre = '{x: -py, y: px, z: -q2e_pkg::HalfPiQ24};
    end
  end

  q2e_pkg::cvec_t s0;
  logic s0_zero;
  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= pre;
      s0_zero <= zero_in;
    end
  end

  // normalize so the larger magnitude reaches bit 40
  always_comb begin
    mx = s0.x[W-1] ? -s0.x : s0.x;
    my = s0.y[W-1] ? -s0.y : s0.y;
    mm = (mx > my) ? mx : my;
    lz = '0;
    for (int b = 0; b <= 40; b++) begin
      if (mm[b]) lz = 6'(40 - b);
    end
    if (mm[W-1:41] != '0) lz = '0;
    norm_in.x = s0.x <<< lz;
    norm_in.y = s0.y <<< lz;
    norm_in.z = s0.z;
  end

  logic zero_p [0:N];
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= norm_in;
      zero_p[0] <= s0_zero;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_p[i+1] <= zero_p[i];
        if (st[i].y < 0) begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - q2e_pkg::atan_tab(i);
        end else begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + q2e_pkg::atan_tab(i);
        end
      end
    end
  end

  always_comb begin
    zr = zero_p[N] ? '0 : st[N].z + q2e_pkg::AngleW'(1024);
    rq = zr[q2e_pkg::AngleW-1:11];
  end

  logic signed [15:0] sat;
  always_comb begin
    if (rq > LIM) sat = 16'(LIM);
    else if (rq < -LIM) sat = -16'(LIM);
    else sat = 16'(rq);
  end

  // delay the saturated angle through LAT registers to align the output
  logic signed [15:0] dly [0:LAT];
  assign dly[0] = sat;
  for (genvar k = 0; k < LAT; k++) begin : g_dly
    always_ff @(posedge clk) if (en) dly[k+1] <= dly[k];
  end
  assign angle = dly[LAT];
endmodule

// ===== design/q2e_front.sv =====
// Front end: products, quadratic forms, clamp and pipelined square root for the pitch cosine
module q2e_front (
  input  logic clk,
  input  logic en,
  input  logic signed [15:0] qx, qy, qz, qw,
  output logic signed [q2e_pkg::SumW-1:0] ry, rx, yy, yx, ps, pc,
  output logic clamped
);
  localparam int P = q2e_pkg::ProdW;
  localparam int S = q2e_pkg::SumW;
  localparam logic signed [S-1:0] One = S'(64'sd1 <<< 28);
  localparam int RL = 29; // root bits: result up to 2^28

  logic signed [P-1:0] wx, yz, xx, yy2, wz, xy, zz, wy, zx;
  always_ff @(posedge clk) begin
    if (en) begin
      wx <= qw * qx; yz <= qy * qz; xx <= qx * qx; yy2 <= qy * qy;
      wz <= qw * qz; xy <= qx * qy; zz <= qz * qz; wy <= qw * qy; zx <= qz * qx;
    end
  end

  logic signed [S-1:0] s_raw, s_c;
  logic cl;
  always_comb begin
    s_raw = (S'(wy) - S'(zx)) <<< 1;
    cl = 1'b0;
    s_c = s_raw;
    if (s_raw > One) begin s_c = One; cl = 1'b1; end
    if (s_raw < -One) begin s_c = -One; cl = 1'b1; end
  end

  logic signed [S-1:0] a_ry, a_rx, a_yy, a_yx, a_s;
  logic a_cl;
  always_ff @(posedge clk) begin
    if (en) begin
      a_ry <= (S'(wx) + S'(yz)) <<< 1;
      a_rx <= One - ((S'(xx) + S'(yy2)) <<< 1);
      a_yy <= (S'(wz) + S'(xy)) <<< 1;
      a_yx <= One - ((S'(yy2) + S'(zz)) <<< 1);
      a_s <= s_c;
      a_cl <= cl;
    end
  end

  // 1 - s*s in Q.56, s magnitude at most 2^28
  logic [28:0] sm;
  logic [57:0] rad;
  assign sm = a_s[S-1] ? 29'(-a_s) : 29'(a_s);

  logic [57:0] sq;
  logic signed [S-1:0] b_ry, b_rx, b_yy, b_yx, b_s;
  logic b_cl;
  logic [28:0] b_sm;
  always_ff @(posedge clk) begin
    if (en) begin
      b_sm <= sm;
      b_ry <= a_ry; b_rx <= a_rx; b_yy <= a_yy; b_yx <= a_yx; b_s <= a_s; b_cl <= a_cl;
    end
  end
  // split square: hi*hi and cross terms kept under 32 bits
  logic [14:0] h;
  logic [13:0] l;
  logic [29:0] hh;
  logic [28:0] hl;
  logic [27:0] ll;
  assign h = b_sm[28:14];
  assign l = b_sm[13:0];
  logic signed [S-1:0] c_ry, c_rx, c_yy, c_yx, c_s;
  logic c_cl;
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= h * h; hl <= h * l; ll <= l * l;
      c_ry <= b_ry; c_rx <= b_rx; c_yy <= b_yy; c_yx <= b_yx; c_s <= b_s; c_cl <= b_cl;
    end
  end
  assign sq = (58'(hh) << 28) + (58'(hl) << 15) + 58'(ll);
  assign rad = (58'd1 << 56) - sq;

  // restoring square root, one result bit per stage
  logic [57:0] rv [0:RL];
  logic [28:0] rr [0:RL];
  logic signed [S-1:0] d_ry [0:RL], d_rx [0:RL], d_yy [0:RL], d_yx [0:RL], d_s [0:RL];
  logic d_cl [0:RL];
  assign rv[0] = rad; assign rr[0] = '0;
  assign d_ry[0] = c_ry; assign d_rx[0] = c_rx; assign d_yy[0] = c_yy;
  assign d_yx[0] = c_yx; assign d_s[0] = c_s; assign d_cl[0] = c_cl;
  for (genvar i = 0; i < RL; i++) begin : g_sqrt
    localparam int B = RL - 1 - i;
    logic [57:0] trial;
    assign trial = (58'(rr[i]) << (B + 1)) + (58'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rv[i] >= trial) begin
          rv[i+1] <= rv[i] - trial;
          rr[i+1] <= rr[i] | (29'd1 << B);
        end else begin
          rv[i+1] <= rv[i];
          rr[i+1] <= rr[i];
        end
        d_ry[i+1] <= d_ry[i]; d_rx[i+1] <= d_rx[i]; d_yy[i+1] <= d_yy[i];
        d_yx[i+1] <= d_yx[i]; d_s[i+1] <= d_s[i]; d_cl[i+1] <= d_cl[i];
      end
    end
  end
  assign ry = d_ry[RL]; assign rx = d_rx[RL]; assign yy = d_yy[RL]; assign yx = d_yx[RL];
  assign ps = d_s[RL];
  assign pc = S'(rr[RL]);
  assign clamped = d_cl[RL];
endmodule

// ===== design/q2e_checker.sv =====
// Port-level checker for the quaternion to Euler angle block, with bind
`include "assert_macros.svh"
module q2e_checker (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic m_axis_tuser
);
  logic [48:0] beat;
  logic signed [15:0] roll, yaw;
  logic signed [14:0] pitch;
  assign beat = {m_axis_tuser, m_axis_tdata};
  assign roll = m_axis_tdata[15:0];
  assign pitch = m_axis_tdata[30:16];
  assign yaw = m_axis_tdata[46:31];

  `CHK_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(beat))
  `CHK_IMPLY(a_roll, clk, rst, m_axis_tvalid, (roll <= 16'sd25736) && (roll >= -16'sd25736))
  `CHK_IMPLY(a_pitch, clk, rst, m_axis_tvalid, (pitch <= 15'sd12868) && (pitch >= -15'sd12868))
  `CHK_IMPLY(a_yaw, clk, rst, m_axis_tvalid, (yaw <= 16'sd25736) && (yaw >= -16'sd25736))
  `CHK_IMPLY(a_pad, clk, rst, m_axis_tvalid, m_axis_tdata[47] == 1'b0)
endmodule

bind quaternion_to_euler_angles_top q2e_checker u_chk (.*);
